[design/pse_pkg.sv]
// Package for the priority schedule evaluator.
// Holds field widths, the stored record type and the controller state type.
// No dependencies.
package pse_pkg;

    localparam int MAX_PROCS_DEF = 16;
    localparam int ID_W          = 16;
    localparam int TIME_W        = 16;
    localparam int PRIO_W        = 8;
    localparam int CLK_W         = 21;
    localparam int SUM_W         = 25;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] arr;
        logic [TIME_W-1:0] burst;
        logic [PRIO_W-1:0] prio;
    } rec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_PICK,
        ST_SCAN,
        ST_CALC,
        ST_COMMIT
    } state_t;

endpackage

[design/priority_schedule_evaluator.sv]
// Top level of the non-preemptive priority schedule evaluator.
// Depends on pse_pkg (widths, rec_t, state_t).
//
// Usage:
//   Input channel (in_valid/in_ready) carries one process record per
//   transaction. Records are kept in a one-port-read, one-port-write record
//   memory in arrival order (equal arrivals keep load order). Insertion walks
//   the memory from the top down, reading then moving one entry at a time, so
//   in_ready drops while each record is inserted. A full store drops further
//   records. A record with last_process set closes the set.
//   Scheduling then runs one pick per result: each pick sweeps all n stored
//   entries through the memory read port, and a second sweep is added when
//   the clock must jump to the earliest pending arrival. A pick starts in a
//   setup state (ST_PICK) and ends in arithmetic (ST_CALC, ST_COMMIT).
//   Output channel (out_valid/out_ready) delivers one transaction per process
//   in run order; last_result marks the final one. The result sits in an
//   output register, so the next pick sweeps while the receiver stalls; only
//   the commit of the next result waits for the register to empty.
//   After the final result is committed the set state (count, marks, clock,
//   totals) clears and in_ready returns, even while that result still waits.
//   Reset (rst_n low, asynchronous) empties the set and drops any pending
//   result; record memory contents are left as they are.
module priority_schedule_evaluator
    import pse_pkg::*;
#(
    parameter int MAX_PROCS = MAX_PROCS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [ID_W-1:0]   process_id,
    input  logic [TIME_W-1:0] arrival_time,
    input  logic [TIME_W-1:0] burst_time,
    input  logic [PRIO_W-1:0] priority_req,
    input  logic              last_process,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ID_W-1:0]   process_id_res,
    output logic [TIME_W-1:0] arrival_time_res,
    output logic [TIME_W-1:0] burst_time_res,
    output logic [PRIO_W-1:0] priority_res,
    output logic [CLK_W-1:0]  completion_time,
    output logic [CLK_W-1:0]  turnaround_time,
    output logic [CLK_W-1:0]  waiting_time,
    output logic [SUM_W-1:0]  sum_turnaround,
    output logic [SUM_W-1:0]  sum_waiting,
    output logic              last_result
);

    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PROCS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // Record memory: one write, one registered read per cycle
    rec_t             mem [MAX_PROCS];
    rec_t             rdata_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    rec_t             wr_data;

    state_t state_reg, state_next;

    // Set state
    logic [MAX_PROCS-1:0] marks_reg, marks_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CLK_W-1:0]     clock_reg, clock_next;
    logic [SUM_W-1:0]     tot_tat_reg, tot_tat_next;
    logic [SUM_W-1:0]     tot_wt_reg, tot_wt_next;
    logic [CNT_W-1:0]     pick_reg, pick_next;

    // Incoming record and insertion pointer
    rec_t             rec_reg, rec_next;
    logic             last_reg, last_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] pos_dec;

    // Sweep state
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    rec_t              best_reg, best_next;
    logic              first_reg, first_next;
    logic [TIME_W-1:0] first_arr_reg, first_arr_next;

    // Arithmetic stage
    logic [CLK_W-1:0] comp_reg, comp_next;
    logic [CLK_W-1:0] wt_reg, wt_next;
    logic [CLK_W-1:0] tat_val;

    // Output register
    logic             out_valid_reg, out_valid_next;
    rec_t             res_rec_reg, res_rec_next;
    logic [CLK_W-1:0] res_comp_reg, res_comp_next;
    logic [CLK_W-1:0] res_tat_reg, res_tat_next;
    logic [CLK_W-1:0] res_wt_reg, res_wt_next;
    logic [SUM_W-1:0] res_stat_reg, res_stat_next;
    logic [SUM_W-1:0] res_swt_reg, res_swt_next;
    logic             res_last_reg, res_last_next;

    logic in_fire;
    logic full;
    logic scan_done;
    logic commit_go;
    logic last_pick;
    logic cand_free;
    logic cand_ready;
    logic shift_up;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign full      = (count_reg >= CNT_MAX);
    assign pos_dec   = pos_reg - CNT_ONE;
    assign shift_up  = (rdata_reg.arr > rec_reg.arr);
    assign scan_done = (scan_reg == count_reg) && !rd_vld_reg;
    assign commit_go = (state_reg == ST_COMMIT) && (!out_valid_reg || out_ready);
    assign last_pick = ((pick_reg + CNT_ONE) == count_reg);
    assign cand_free = !marks_reg[rd_idx_reg];
    assign cand_ready = cand_free && ({{(CLK_W-TIME_W){1'b0}}, rdata_reg.arr} <= clock_reg);
    assign tat_val   = wt_reg + {{(CLK_W-TIME_W){1'b0}}, best_reg.burst};

    // Record memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!full)
                    begin
                        state_next = ST_INS_RD;
                    end
                    else if (last_process)
                    begin
                        state_next = ST_PICK;
                    end
                end
            end
            ST_INS_RD:
            begin
                if (pos_reg == '0)
                begin
                    state_next = last_reg ? ST_PICK : ST_IDLE;
                end
                else
                begin
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP:
            begin
                if (shift_up)
                begin
                    state_next = ST_INS_RD;
                end
                else
                begin
                    state_next = last_reg ? ST_PICK : ST_IDLE;
                end
            end
            ST_PICK:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    if (found_reg)
                    begin
                        state_next = ST_CALC;
                    end
                    else if (first_reg)
                    begin
                        state_next = ST_PICK;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CALC:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (commit_go)
                begin
                    state_next = last_pick ? ST_IDLE : ST_PICK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and control outputs
    always_comb
    begin
        rd_addr        = scan_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = pos_reg[IDX_W-1:0];
        wr_data        = rec_reg;

        marks_next     = marks_reg;
        count_next     = count_reg;
        clock_next     = clock_reg;
        tot_tat_next   = tot_tat_reg;
        tot_wt_next    = tot_wt_reg;
        pick_next      = pick_reg;
        rec_next       = rec_reg;
        last_next      = last_reg;
        pos_next       = pos_reg;
        scan_next      = scan_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = scan_reg[IDX_W-1:0];
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_next      = best_reg;
        first_next     = first_reg;
        first_arr_next = first_arr_reg;
        comp_next      = comp_reg;
        wt_next        = wt_reg;

        out_valid_next = out_valid_reg && !out_ready;
        res_rec_next   = res_rec_reg;
        res_comp_next  = res_comp_reg;
        res_tat_next   = res_tat_reg;
        res_wt_next    = res_wt_reg;
        res_stat_next  = res_stat_reg;
        res_swt_next   = res_swt_reg;
        res_last_next  = res_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Latch the record; a full store drops it
                if (in_fire)
                begin
                    rec_next.id    = process_id;
                    rec_next.arr   = arrival_time;
                    rec_next.burst = burst_time;
                    rec_next.prio  = priority_req;
                    last_next      = last_process;
                    pos_next       = count_reg;
                end
            end
            ST_INS_RD:
            begin
                rd_addr = pos_dec[IDX_W-1:0];
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_ONE;
                end
            end
            ST_INS_CMP:
            begin
                // Move the later-arriving entry up one slot, or drop the record in
                wr_en = 1'b1;
                if (shift_up)
                begin
                    wr_data  = rdata_reg;
                    pos_next = pos_dec;
                end
                else
                begin
                    count_next = count_reg + CNT_ONE;
                end
            end
            ST_PICK:
            begin
                scan_next  = '0;
                found_next = 1'b0;
                first_next = 1'b0;
            end
            ST_SCAN:
            begin
                if (scan_reg != count_reg)
                begin
                    rd_vld_next = 1'b1;
                    scan_next   = scan_reg + CNT_ONE;
                end
                if (rd_vld_reg)
                begin
                    if (cand_ready && (!found_reg || (rdata_reg.prio > best_reg.prio)))
                    begin
                        found_next    = 1'b1;
                        best_idx_next = rd_idx_reg;
                        best_next     = rdata_reg;
                    end
                    if (cand_free && !first_reg)
                    begin
                        first_next     = 1'b1;
                        first_arr_next = rdata_reg.arr;
                    end
                end
                if (scan_done && !found_reg)
                begin
                    if (first_reg)
                    begin
                        // Nothing ready: jump to the earliest pending arrival
                        clock_next = {{(CLK_W-TIME_W){1'b0}}, first_arr_reg};
                    end
                    else
                    begin
                        marks_next   = '0;
                        count_next   = '0;
                        clock_next   = '0;
                        tot_tat_next = '0;
                        tot_wt_next  = '0;
                        pick_next    = '0;
                    end
                end
            end
            ST_CALC:
            begin
                comp_next = clock_reg + {{(CLK_W-TIME_W){1'b0}}, best_reg.burst};
                wt_next   = clock_reg - {{(CLK_W-TIME_W){1'b0}}, best_reg.arr};
            end
            ST_COMMIT:
            begin
                if (commit_go)
                begin
                    out_valid_next = 1'b1;
                    res_rec_next   = best_reg;
                    res_comp_next  = comp_reg;
                    res_tat_next   = tat_val;
                    res_wt_next    = wt_reg;
                    res_stat_next  = tot_tat_reg + {{(SUM_W-CLK_W){1'b0}}, tat_val};
                    res_swt_next   = tot_wt_reg + {{(SUM_W-CLK_W){1'b0}}, wt_reg};
                    res_last_next  = last_pick;
                    if (last_pick)
                    begin
                        // End of set: clear for the next one
                        marks_next   = '0;
                        count_next   = '0;
                        clock_next   = '0;
                        tot_tat_next = '0;
                        tot_wt_next  = '0;
                        pick_next    = '0;
                    end
                    else
                    begin
                        marks_next[best_idx_reg] = 1'b1;
                        clock_next   = comp_reg;
                        tot_tat_next = res_stat_next;
                        tot_wt_next  = res_swt_next;
                        pick_next    = pick_reg + CNT_ONE;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            marks_reg     <= '0;
            count_reg     <= '0;
            clock_reg     <= '0;
            tot_tat_reg   <= '0;
            tot_wt_reg    <= '0;
            pick_reg      <= '0;
            pos_reg       <= '0;
            last_reg      <= 1'b0;
            scan_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            marks_reg     <= marks_next;
            count_reg     <= count_next;
            clock_reg     <= clock_next;
            tot_tat_reg   <= tot_tat_next;
            tot_wt_reg    <= tot_wt_next;
            pick_reg      <= pick_next;
            pos_reg       <= pos_next;
            last_reg      <= last_next;
            scan_reg      <= scan_next;
            rd_vld_reg    <= rd_vld_next;
            found_reg     <= found_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rec_reg       <= rec_next;
        rd_idx_reg    <= rd_idx_next;
        best_idx_reg  <= best_idx_next;
        best_reg      <= best_next;
        first_arr_reg <= first_arr_next;
        comp_reg      <= comp_next;
        wt_reg        <= wt_next;
        res_rec_reg   <= res_rec_next;
        res_comp_reg  <= res_comp_next;
        res_tat_reg   <= res_tat_next;
        res_wt_reg    <= res_wt_next;
        res_stat_reg  <= res_stat_next;
        res_swt_reg   <= res_swt_next;
        res_last_reg  <= res_last_next;
    end

    assign out_valid        = out_valid_reg;
    assign process_id_res   = res_rec_reg.id;
    assign arrival_time_res = res_rec_reg.arr;
    assign burst_time_res   = res_rec_reg.burst;
    assign priority_res     = res_rec_reg.prio;
    assign completion_time  = res_comp_reg;
    assign turnaround_time  = res_tat_reg;
    assign waiting_time     = res_wt_reg;
    assign sum_turnaround   = res_stat_reg;
    assign sum_waiting      = res_swt_reg;
    assign last_result      = res_last_reg;

endmodule
